// ===== design/ovls_pkg.sv =====
// Shared types and constants for the ordered value list block.
package ovls_pkg;

  localparam int VAL_W  = 31;
  localparam int MEAN_W = 39;
  localparam int FRAC_W = 8;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

// ===== design/ovls_if.sv =====
// Valid/ready channel interfaces for commands and result items.
interface ovls_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ovls_pkg::VAL_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface ovls_out_if #(
  parameter int CNT_W = 7
);
  logic                        valid;
  logic                        ready;
  ovls_pkg::status_t           status;
  logic [CNT_W-1:0]            entry_count;
  logic [ovls_pkg::VAL_W-1:0]  head_value;
  logic [ovls_pkg::VAL_W-1:0]  tail_value;
  logic [ovls_pkg::VAL_W-1:0]  min_value;
  logic [ovls_pkg::VAL_W-1:0]  max_value;
  logic [ovls_pkg::MEAN_W-1:0] mean_q8;

  modport source (output valid, status, entry_count, head_value, tail_value,
                  min_value, max_value, mean_q8, input ready);
  modport sink   (input valid, status, entry_count, head_value, tail_value,
                  min_value, max_value, mean_q8, output ready);
endinterface

// ===== design/ordered_value_list_with_stats_top.sv =====
// Ordered value list: append / delete-first-match with running statistics.
// Each command makes a pass over the list (a new append included), then a restoring divide
//   for the mean, skipped when the list ends up empty, and then loads the output register.
// One command at a time: a new command is taken only after the last result has been loaded
//   into the output register; a result not yet taken holds the block.
// Reset (synchronous, active low) empties the list, holds ready low; memory is not cleared.
module ordered_value_list_with_stats_top #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ovls_in_if.sink     in_if,
  ovls_out_if.source  out_if
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int VAL_W = ovls_pkg::VAL_W;
  localparam int SUM_W = VAL_W + CNT_W;
  localparam int DVD_W = SUM_W + ovls_pkg::FRAC_W;
  localparam int DCT_W = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic                       cmd_r;
  logic [VAL_W-1:0]           value_r;
  ovls_pkg::status_t          status_r;
  logic [CNT_W-1:0]           iss_idx_r;
  logic [CNT_W-1:0]           pidx_r;
  logic                       pv_r;
  logic                       found_r;
  logic                       have_r;
  logic [VAL_W-1:0]           head_r;
  logic [VAL_W-1:0]           tail_r;
  logic [VAL_W-1:0]           min_r;
  logic [VAL_W-1:0]           max_r;
  logic [SUM_W-1:0]           sum_r;
  logic [DVD_W-1:0]           dvd_r;
  logic [CNT_W-1:0]           rem_r;
  logic [DCT_W-1:0]           div_cnt_r;
  logic                       out_valid_r;

  logic [VAL_W-1:0]           mem [CAPACITY];
  logic [VAL_W-1:0]           rd_data_r;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [VAL_W-1:0]           wr_data;

  logic                       in_xfer;
  logic                       do_append;
  logic                       issue;
  logic                       match;
  logic                       keep;
  logic                       scan_end;
  logic [CNT_W-1:0]           cnt_after;
  logic [CNT_W:0]             rem_sh;
  logic [CNT_W:0]             rem_diff;
  logic                       rem_ge;

  assign in_xfer   = in_if.valid && in_if.ready;
  assign do_append = in_xfer && (in_if.cmd == ovls_pkg::CMD_APPEND)
                     && (count_r != CNT_W'(CAPACITY));
  assign issue     = (state_r == S_SCAN) && (iss_idx_r < count_r);
  assign rd_addr   = iss_idx_r[IDX_W-1:0];
  assign match     = pv_r && (cmd_r == ovls_pkg::CMD_DELETE) && !found_r
                     && (rd_data_r == value_r);
  assign keep      = pv_r && !match;
  assign scan_end  = (state_r == S_SCAN) && !issue && !pv_r;
  assign cnt_after = count_r - CNT_W'(found_r);

  // Write port: appended value on the command transfer, else close the gap
  // by moving each entry after the match down by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = in_if.value;
    if (do_append) begin
      wr_en = 1'b1;
    end else if (keep && found_r) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pidx_r - CNT_W'(1));
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Restoring divider step, one quotient bit a cycle
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign rem_ge   = (rem_sh >= {1'b0, count_r});

  assign in_if.ready  = rst_n && (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_if.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r     <= in_if.cmd;
            value_r   <= in_if.value;
            iss_idx_r <= '0;
            found_r   <= 1'b0;
            have_r    <= 1'b0;
            head_r    <= '0;
            tail_r    <= '0;
            min_r     <= '0;
            max_r     <= '0;
            sum_r     <= '0;
            if (in_if.cmd == ovls_pkg::CMD_APPEND) begin
              if (do_append) begin
                count_r  <= count_r + CNT_W'(1);
                status_r <= ovls_pkg::ST_OK;
              end else begin
                status_r <= ovls_pkg::ST_FULL;
              end
            end else begin
              status_r <= ovls_pkg::ST_OK;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv_r <= issue;
          if (issue) begin
            iss_idx_r <= iss_idx_r + CNT_W'(1);
            pidx_r    <= iss_idx_r;
          end
          if (match) begin
            found_r <= 1'b1;
          end
          if (keep) begin
            have_r <= 1'b1;
            tail_r <= rd_data_r;
            sum_r  <= sum_r + SUM_W'(rd_data_r);
            if (!have_r) begin
              head_r <= rd_data_r;
              min_r  <= rd_data_r;
              max_r  <= rd_data_r;
            end else begin
              if (rd_data_r < min_r) min_r <= rd_data_r;
              if (rd_data_r > max_r) max_r <= rd_data_r;
            end
          end
          if (scan_end) begin
            count_r <= cnt_after;
            if ((cmd_r == ovls_pkg::CMD_DELETE) && !found_r) begin
              status_r <= ovls_pkg::ST_NOT_FOUND;
            end
            rem_r     <= '0;
            div_cnt_r <= DCT_W'(DVD_W);
            if (cnt_after == '0) begin
              dvd_r   <= '0;
              state_r <= S_DONE;
            end else begin
              dvd_r   <= {sum_r, {ovls_pkg::FRAC_W{1'b0}}};
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r     <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          dvd_r     <= {dvd_r[DVD_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r - DCT_W'(1);
          if (div_cnt_r == DCT_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r        <= 1'b1;
            out_if.status      <= status_r;
            out_if.entry_count <= count_r;
            out_if.head_value  <= head_r;
            out_if.tail_value  <= tail_r;
            out_if.min_value   <= min_r;
            out_if.max_value   <= max_r;
            out_if.mean_q8     <= dvd_r[ovls_pkg::MEAN_W-1:0];
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_if.status == ovls_pkg::ST_FULL))
      |-> (out_if.entry_count == CNT_W'(CAPACITY)))
    else $error("full status with spare room");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_if.entry_count == '0))
      |-> ((out_if.head_value == '0) && (out_if.max_value == '0)
           && (out_if.mean_q8 == '0)))
    else $error("non-zero statistics for an empty list");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_if.entry_count != '0))
      |-> ((out_if.min_value <= out_if.head_value)
           && (out_if.head_value <= out_if.max_value)
           && (out_if.min_value <= out_if.tail_value)
           && (out_if.tail_value <= out_if.max_value)))
    else $error("min/max inconsistent with head or tail");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && wr_en) |-> (pidx_r < count_r) && (pidx_r != '0))
    else $error("gap-closing write outside the list");
`endif

endmodule
